// File: rtl/tbl_pkg.sv
// shared types and constants of the per-client token bucket limiter
`timescale 1ns / 1ps
package tbl_pkg;
	localparam int CLIENT_COUNT = 256;
	localparam int FRAC_BITS    = 16;
	localparam int IDX_W        = $clog2(CLIENT_COUNT);
	localparam int IN_IDX_W     = 8;
	localparam int TIME_W       = 32;
	localparam int LEVEL_W      = 32;
	localparam int MAX_W        = 16;
	localparam int RATE_W       = 32;
	localparam int PROD_W       = TIME_W + RATE_W;
	localparam int CAP_FULL_W   = MAX_W + FRAC_BITS;
	localparam int USED_W       = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MAX_W-1:0]   MAX_TOKENS_RESET  = MAX_W'(100);
	localparam logic [RATE_W-1:0]  REFILL_RATE_RESET = RATE_W'(109226);
	localparam logic [LEVEL_W-1:0] LEVEL_ONE         = LEVEL_W'(1) << FRAC_BITS;
	localparam logic [LEVEL_W-1:0] LEVEL_ALL_ONES    = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_TOKENS  = CFG_IDX_W'(0),
		REG_REFILL_RATE = CFG_IDX_W'(1)
	} cfg_reg_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic              first;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] now;
	} req_item_t;
endpackage

// File: rtl/tbl_req_if.sv
// request channel: client index and timestamp
`timescale 1ns / 1ps
interface tbl_req_if;
	logic                             valid;
	logic                             ready;
	logic [tbl_pkg::IN_IDX_W-1:0]     client_index;
	logic [tbl_pkg::TIME_W-1:0]       timestamp;

	modport source (output valid, output client_index, output timestamp, input ready);
	modport sink (input valid, input client_index, input timestamp, output ready);
endinterface

// File: rtl/tbl_rsp_if.sv
// result channel: verdict and used count
`timescale 1ns / 1ps
interface tbl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         allowed;
	logic [tbl_pkg::USED_W-1:0]   used_count;

	modport source (output valid, output allowed, output used_count, input ready);
	modport sink (input valid, input allowed, input used_count, output ready);
endinterface

// File: rtl/tbl_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
interface tbl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tbl_pkg::CFG_IDX_W-1:0]    index;
	logic [tbl_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/tbl_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module tbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/tbl_front.sv
// front end: takes requests, wraps the index and marks first-seen clients
`timescale 1ns / 1ps
module tbl_front (
	input  logic               clk,
	input  logic               arst_n,
	tbl_req_if.sink            req,
	output logic               push_valid,
	input  logic               push_ready,
	output tbl_pkg::req_item_t push_item
);
	logic [tbl_pkg::CLIENT_COUNT-1:0] seen_q;
	logic [tbl_pkg::IDX_W-1:0]        idx;
	logic                             take;

	assign idx        = req.client_index[tbl_pkg::IDX_W-1:0];
	assign req.ready  = push_ready;
	assign push_valid = req.valid;
	assign take       = req.valid && push_ready;

	assign push_item.first = !seen_q[idx];
	assign push_item.idx   = idx;
	assign push_item.now   = req.timestamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (take) begin
			seen_q[idx] <= 1'b1;
		end
	end
endmodule

// File: rtl/tbl_queue.sv
// short queue between front and back end
`timescale 1ns / 1ps
module tbl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  tbl_pkg::req_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output tbl_pkg::req_item_t pop_item
);
	tbl_pkg::req_item_t              slot_q [tbl_pkg::QUEUE_DEPTH];
	logic [tbl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [tbl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [tbl_pkg::QCNT_W-1:0]      count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q != tbl_pkg::QCNT_W'(tbl_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + tbl_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - tbl_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: rtl/tbl_back.sv
// back end: bucket read-modify-write, refill, admission and result register
`timescale 1ns / 1ps
module tbl_back (
	input  logic               clk,
	input  logic               arst_n,
	tbl_cfg_if.sink            cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  tbl_pkg::req_item_t pop_item,
	tbl_rsp_if.source          rsp
);
	typedef enum logic [4:0] {
		ST_READ   = 5'b00001,
		ST_ELAPSE = 5'b00010,
		ST_MULT   = 5'b00100,
		ST_SAT    = 5'b01000,
		ST_WRITE  = 5'b10000
	} state_t;

	state_t                              state_q;
	logic [tbl_pkg::MAX_W-1:0]           max_q;
	logic [tbl_pkg::RATE_W-1:0]          rate_q;
	tbl_pkg::req_item_t                  cur_q;
	logic [tbl_pkg::LEVEL_W-1:0]         level_s1;
	logic [tbl_pkg::TIME_W-1:0]          elapsed_s1;
	logic [tbl_pkg::PROD_W-1:0]          prod_s2;
	logic [tbl_pkg::LEVEL_W-1:0]         level_s3;
	logic                                out_valid_q;
	logic                                allowed_q;
	logic [tbl_pkg::USED_W-1:0]          used_q;

	logic [tbl_pkg::CAP_FULL_W-1:0]      cap_full;
	logic [tbl_pkg::LEVEL_W-1:0]         cap;
	logic [tbl_pkg::LEVEL_W-1:0]         level_rd;
	logic [tbl_pkg::TIME_W-1:0]          time_rd;
	logic [tbl_pkg::LEVEL_W-1:0]         base_level;
	logic [tbl_pkg::TIME_W-1:0]          base_time;
	logic [tbl_pkg::PROD_W-1:0]          sum;
	logic                                ok;
	logic [tbl_pkg::LEVEL_W-1:0]         new_level;
	logic [tbl_pkg::LEVEL_W-1:0]         whole;
	logic [tbl_pkg::LEVEL_W-1:0]         max_ext;
	logic [tbl_pkg::USED_W-1:0]          used;
	logic                                pop;
	logic                                wr_en;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= tbl_pkg::MAX_TOKENS_RESET;
			rate_q <= tbl_pkg::REFILL_RATE_RESET;
		end else if (cfg.valid) begin
			unique case (tbl_pkg::cfg_reg_t'(cfg.index))
				tbl_pkg::REG_MAX_TOKENS:  max_q  <= cfg.data[tbl_pkg::MAX_W-1:0];
				tbl_pkg::REG_REFILL_RATE: rate_q <= cfg.data[tbl_pkg::RATE_W-1:0];
			endcase
		end
	end

	// capacity in fixed point, saturated to the level width
	assign cap_full = tbl_pkg::CAP_FULL_W'(max_q) << tbl_pkg::FRAC_BITS;
	assign cap = ((cap_full >> tbl_pkg::LEVEL_W) != '0) ? tbl_pkg::LEVEL_ALL_ONES
		: tbl_pkg::LEVEL_W'(cap_full);

	assign pop       = (state_q == ST_READ) && pop_valid;
	assign pop_ready = state_q == ST_READ;
	assign wr_en     = (state_q == ST_WRITE) && (!out_valid_q || rsp.ready);

	// bucket state
	assign sum       = {{(tbl_pkg::PROD_W - tbl_pkg::LEVEL_W){1'b0}}, level_s1} + prod_s2;
	assign ok        = level_s3 >= tbl_pkg::LEVEL_ONE;
	assign new_level = ok ? level_s3 - tbl_pkg::LEVEL_ONE : level_s3;
	assign whole     = new_level >> tbl_pkg::FRAC_BITS;
	assign max_ext   = tbl_pkg::LEVEL_W'(max_q);
	assign used      = (whole >= max_ext) ? '0 : tbl_pkg::USED_W'(max_ext - whole);

	tbl_ram #(
		.WIDTH(tbl_pkg::LEVEL_W),
		.DEPTH(tbl_pkg::CLIENT_COUNT)
	) u_level_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cur_q.idx),
		.wdata(new_level),
		.re   (pop),
		.raddr(pop_item.idx),
		.rdata(level_rd)
	);

	tbl_ram #(
		.WIDTH(tbl_pkg::TIME_W),
		.DEPTH(tbl_pkg::CLIENT_COUNT)
	) u_time_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cur_q.idx),
		.wdata(cur_q.now),
		.re   (pop),
		.raddr(pop_item.idx),
		.rdata(time_rd)
	);

	// a new client starts full at the current time
	assign base_level = cur_q.first ? cap : level_rd;
	assign base_time  = cur_q.first ? cur_q.now : time_rd;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_item;
		end
		if (state_q == ST_ELAPSE) begin
			level_s1   <= base_level;
			elapsed_s1 <= (cur_q.now > base_time) ? cur_q.now - base_time : '0;
		end
		if (state_q == ST_MULT) begin
			prod_s2 <= tbl_pkg::PROD_W'(elapsed_s1) * tbl_pkg::PROD_W'(rate_q);
		end
		if (state_q == ST_SAT) begin
			level_s3 <= (sum > tbl_pkg::PROD_W'(cap)) ? cap : tbl_pkg::LEVEL_W'(sum);
		end
		if (wr_en) begin
			allowed_q <= ok;
			used_q    <= used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READ;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_READ:   if (pop_valid) state_q <= ST_ELAPSE;
				ST_ELAPSE: state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_SAT;
				ST_SAT:    state_q <= ST_WRITE;
				ST_WRITE:  if (wr_en) state_q <= ST_READ;
				default:   state_q <= ST_READ;
			endcase
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.allowed    = allowed_q;
	assign rsp.used_count = used_q;

	a_level_capped: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> new_level <= cap)
		else $error("stored bucket level above capacity");
	a_allowed_used: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.allowed) |-> rsp.used_count != '0)
		else $error("admitted word reports zero used tokens");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> tbl_pkg::MAX_W'(rsp.used_count) <= max_q)
		else $error("used count above capacity");
	a_pop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_ELAPSE)
		else $error("dequeued word did not start processing");
endmodule

// File: rtl/per_client_token_bucket_limiter_top.sv
// Per-client token bucket limiter. Each request word names a client and a time in
// whole seconds and returns one result word: allowed and the used token count. The
// front end accepts one request per cycle while the queue has room, into a two-entry
// queue, and tracks which clients have been seen in flip-flops cleared at reset, so no
// clearing pass is needed. The back end serves one request at a time, through the
// read-modify-write loop over the bucket level and last-time memories: read, elapsed
// time, 32x32 multiply, saturate, write; the write waits while the previous result
// word has not been accepted.
// Configuration (index 0 max_tokens, index 1 refill_rate in Q16.16) is always ready.
`timescale 1ns / 1ps
module per_client_token_bucket_limiter_top (
	input  logic      clk,
	input  logic      arst_n,
	tbl_req_if.sink   req,
	tbl_rsp_if.source rsp,
	tbl_cfg_if.sink   cfg
);
	logic               push_valid;
	logic               push_ready;
	tbl_pkg::req_item_t push_item;
	logic               pop_valid;
	logic               pop_ready;
	tbl_pkg::req_item_t pop_item;

	tbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	tbl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	tbl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.rsp      (rsp)
	);
endmodule
